### src/cmle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmle_pkg
// Shared types and constants for the column mean line extractor.
// ----------------------------------------------------------------------------
package cmle_pkg;

    localparam int IMAGE_WIDTH  = 4096;
    localparam int FRAME_ROWS   = 4096;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int LVL_W   = 8;
    localparam int RSUM_W  = 24;
    localparam int LSUM_W  = 20;
    localparam int CNT_W   = 13;
    localparam int QUO_W   = 12;
    localparam int STEP_W  = 4;

    // pixels per column stop at the image height, capped at 4096
    localparam int CNT_LIMIT_I = (FRAME_ROWS < 4096) ? FRAME_ROWS : 4096;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_I);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [RSUM_W-1:0] row_sum;
        logic [LSUM_W-1:0] lvl_sum;
        logic [CNT_W-1:0]  cnt;
        logic              eor;
    } t_job;

    // up to two closed groups per input transaction, oldest in job0
    typedef struct packed {
        logic wr0;
        logic wr1;
        t_job job0;
        t_job job1;
    } t_push;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

### src/cmle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmle_front
// Accumulates row sum, level sum and count of the open column; pushes a job
// for every closed group into the queue.
// ----------------------------------------------------------------------------
module cmle_front
    import cmle_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tvalid,
    output logic                  o_tready,
    input  wire logic [COL_W-1:0] i_col,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic [LVL_W-1:0] i_lvl,
    input  wire logic             i_last,
    input  wire logic             i_room,
    output t_push                 o_push
);

    logic [COL_W-1:0]  r_col,     n_col;
    logic [RSUM_W-1:0] r_row_sum, n_row_sum;
    logic [LSUM_W-1:0] r_lvl_sum, n_lvl_sum;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;

    logic              accept;
    logic              close;
    logic [RSUM_W-1:0] base_row;
    logic [LSUM_W-1:0] base_lvl;
    logic [CNT_W-1:0]  base_cnt;
    logic [RSUM_W-1:0] grp_row;
    logic [LSUM_W-1:0] grp_lvl;
    logic [CNT_W-1:0]  grp_cnt;
    t_job              old_job;
    t_job              new_job;

    assign o_tready = i_room;
    assign accept   = i_tvalid && i_room;
    assign close    = (r_cnt != '0) && (i_col != r_col);

    always_comb begin
        base_row = close ? '0 : r_row_sum;
        base_lvl = close ? '0 : r_lvl_sum;
        base_cnt = close ? '0 : r_cnt;
        // drop the pixel once the column is full
        if (base_cnt < CNT_LIMIT) begin
            grp_row = base_row + RSUM_W'(i_row);
            grp_lvl = base_lvl + LSUM_W'(i_lvl);
            grp_cnt = base_cnt + CNT_W'(1);
        end else begin
            grp_row = base_row;
            grp_lvl = base_lvl;
            grp_cnt = base_cnt;
        end

        old_job = '{col: r_col, row_sum: r_row_sum, lvl_sum: r_lvl_sum,
                    cnt: r_cnt, eor: !i_last};
        new_job = '{col: i_col, row_sum: grp_row, lvl_sum: grp_lvl,
                    cnt: grp_cnt, eor: 1'b1};

        o_push.wr0  = accept && (close || i_last);
        o_push.wr1  = accept && close && i_last;
        o_push.job0 = close ? old_job : new_job;
        o_push.job1 = new_job;

        n_col     = r_col;
        n_row_sum = r_row_sum;
        n_lvl_sum = r_lvl_sum;
        n_cnt     = r_cnt;
        if (accept) begin
            n_col = i_col;
            if (i_last) begin
                n_row_sum = '0;
                n_lvl_sum = '0;
                n_cnt     = '0;
            end else begin
                n_row_sum = grp_row;
                n_lvl_sum = grp_lvl;
                n_cnt     = grp_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_sum <= '0;
            r_lvl_sum <= '0;
            r_cnt     <= '0;
        end else begin
            r_col     <= n_col;
            r_row_sum <= n_row_sum;
            r_lvl_sum <= n_lvl_sum;
            r_cnt     <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### src/cmle_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmle_queue
// Small job queue with two write slots and one read slot per cycle.
// ----------------------------------------------------------------------------
module cmle_queue
    import cmle_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output t_job       o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [QPTR_W-1:0] wp_next;

    assign wp_next    = r_wp + QPTR_W'(1);
    assign o_room     = r_count <= QCNT_W'(QUEUE_DEPTH - 2);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp + QPTR_W'(i_push.wr0) + QPTR_W'(i_push.wr1);
        n_rp    = r_rp + QPTR_W'(i_pop);
        n_count = r_count + QCNT_W'(i_push.wr0) + QCNT_W'(i_push.wr1)
                  - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wp] <= i_push.job0;
        end
        if (i_push.wr1) begin
            r_mem[wp_next] <= i_push.job1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.wr1 |-> i_push.wr0)
        else $error("second slot written without first");
`endif

endmodule
`default_nettype wire

### src/cmle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmle_back
// Divides both sums of a job by its count, one quotient bit per cycle,
// rounds half to even and holds the result in an output register.
// ----------------------------------------------------------------------------
module cmle_back
    import cmle_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_nonempty,
    input  wire t_job             i_head,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [COL_W-1:0]      o_col,
    output logic [ROW_W-1:0]      o_row_mean,
    output logic [LVL_W-1:0]      o_lvl_mean,
    output logic                  o_eor
);

    t_back_state       r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [RSUM_W-1:0] r_row_rem;
    logic [LSUM_W-1:0] r_lvl_rem;
    logic [RSUM_W-1:0] r_dsh;
    logic [CNT_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_row_q;
    logic [QUO_W-1:0]  r_lvl_q;
    logic [COL_W-1:0]  r_job_col;
    logic              r_job_eor;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [LVL_W-1:0]  r_out_lvl;
    logic              r_out_eor;

    logic              load_job;
    logic              div_step;
    logic              load_out;
    logic              row_ge;
    logic              lvl_ge;
    logic [CNT_W:0]    row_twice;
    logic [CNT_W:0]    lvl_twice;
    logic [CNT_W:0]    den_ext;
    logic              row_up;
    logic              lvl_up;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_nonempty) n_state = BK_DIV;
            BK_DIV:  if (r_step == '0) n_state = BK_DONE;
            BK_DONE: if (!r_out_valid || i_tready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        load_job = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: load_job = i_nonempty;
            BK_DIV:  div_step = 1'b1;
            BK_DONE: load_out = !r_out_valid || i_tready;
            default: ;
        endcase
    end

    assign o_pop = load_job;

    assign row_ge = r_row_rem >= r_dsh;
    assign lvl_ge = RSUM_W'(r_lvl_rem) >= r_dsh;

    // remainders are below the count here, so their low bits suffice
    assign den_ext   = {1'b0, r_den};
    assign row_twice = {r_row_rem[CNT_W-1:0], 1'b0};
    assign lvl_twice = {r_lvl_rem[CNT_W-1:0], 1'b0};
    assign row_up    = (row_twice > den_ext) || ((row_twice == den_ext) && r_row_q[0]);
    assign lvl_up    = (lvl_twice > den_ext) || ((lvl_twice == den_ext) && r_lvl_q[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_step    <= STEP_W'(QUO_W - 1);
            r_row_rem <= i_head.row_sum;
            r_lvl_rem <= i_head.lvl_sum;
            r_den     <= i_head.cnt;
            r_dsh     <= RSUM_W'(i_head.cnt) << (QUO_W - 1);
            r_row_q   <= '0;
            r_lvl_q   <= '0;
            r_job_col <= i_head.col;
            r_job_eor <= i_head.eor;
        end else if (div_step) begin
            r_step  <= r_step - STEP_W'(1);
            r_dsh   <= r_dsh >> 1;
            r_row_q <= {r_row_q[QUO_W-2:0], row_ge};
            r_lvl_q <= {r_lvl_q[QUO_W-2:0], lvl_ge};
            if (row_ge) begin
                r_row_rem <= r_row_rem - r_dsh;
            end
            if (lvl_ge) begin
                r_lvl_rem <= r_lvl_rem - r_dsh[LSUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_col <= r_job_col;
            r_out_row <= r_row_q + ROW_W'(row_up);
            r_out_lvl <= r_lvl_q[LVL_W-1:0] + LVL_W'(lvl_up);
            r_out_eor <= r_job_eor;
        end
    end

    assign o_tvalid   = r_out_valid;
    assign o_col      = r_out_col;
    assign o_row_mean = r_out_row;
    assign o_lvl_mean = r_out_lvl;
    assign o_eor      = r_out_eor;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == BK_DIV && r_step == STEP_W'(QUO_W - 1))
        else $error("job taken without starting division");

    a_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> r_den != '0)
        else $error("division by a zero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DONE && r_out_valid && !i_tready |=> r_state == BK_DONE)
        else $error("result lost while output stalled");
`endif

endmodule
`default_nettype wire

### src/column_mean_line_extractor_unit.sv
`default_nettype none
// Path: an item that closes a group gives its result through the queue pop, the
// 12 divider steps and the rounding into the output register.
// Throughput: one item per cycle into the front while the job queue has room;
// each result holds the shared bit-serial divider in the back until it is registered.
// Reset: synchronous, active low; clears the open group, queue and output.
// ----------------------------------------------------------------------------
// column_mean_line_extractor_unit
// Per-column mean row and mean level of the pixels of a frame.
// ----------------------------------------------------------------------------
module column_mean_line_extractor_unit
    import cmle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // column[11:0], row[23:12], level[31:24]
    input  wire logic        i_s_axis_tlast,  // last_pixel
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // out_column[11:0], row_mean[23:12],
                                              // level_mean[31:24]
    output logic             o_m_axis_tlast   // end_of_run
);

    t_push            push;
    logic             room;
    logic             pop;
    logic             nonempty;
    t_job             head;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [LVL_W-1:0] out_lvl;

    cmle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_col    (i_s_axis_tdata[11:0]),
        .i_row    (i_s_axis_tdata[23:12]),
        .i_lvl    (i_s_axis_tdata[31:24]),
        .i_last   (i_s_axis_tlast),
        .i_room   (room),
        .o_push   (push)
    );

    cmle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room     (room),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    cmle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_col      (out_col),
        .o_row_mean (out_row),
        .o_lvl_mean (out_lvl),
        .o_eor      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_lvl, out_row, out_col};

endmodule
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Column mean line extractor testbench
// Drives pixel streams into the unit and predicts the rounded mean row and
// level of each closed column, checking every output transaction in order.
// Covers column closes and flushes, back-pressure from a long output
// hold-off, and random frames with noise and column drops.
// ----------------------------------------------------------------------------
module testbench;
    import cmle_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        bit [11:0] column;
        bit [11:0] row_mean;
        bit [7:0]  level_mean;
        bit        end_of_run;
    } column_mean_t;

    class column_mean_predictor;
        column_mean_t pending_means[$];
        bit [11:0]    open_column;
        bit [23:0]    row_total;
        bit [19:0]    level_total;
        bit [12:0]    pixel_count;
        int unsigned  pixel_cap;
        int unsigned  errors;

        function new();
            pixel_cap   = (FRAME_ROWS < 4096) ? FRAME_ROWS : 4096;
            open_column = '0;
            row_total   = '0;
            level_total = '0;
            pixel_count = '0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return pending_means.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // sum / count, ties go to the even quotient
        function int unsigned mean_half_even(int unsigned sum, int unsigned cnt);
            int unsigned q;
            int unsigned r;
            q = sum / cnt;
            r = sum % cnt;
            if (2 * r > cnt || (2 * r == cnt && q[0]))
                q++;
            return q;
        endfunction

        function column_mean_t close_column();
            column_mean_t res;
            res.column     = open_column;
            res.row_mean   = 12'(mean_half_even(row_total, pixel_count));
            res.level_mean = 8'(mean_half_even(level_total, pixel_count));
            res.end_of_run = 1'b0;
            row_total   = '0;
            level_total = '0;
            pixel_count = '0;
            return res;
        endfunction

        function void note_pixel(bit [11:0] col, bit [11:0] row, bit [7:0] lvl, bit last);
            column_mean_t res[2];
            int           k;
            k = 0;
            if (pixel_count != 0 && col != open_column) begin
                res[k] = close_column();
                k++;
            end
            open_column = col;
            // drop the pixel once the column is full
            if (pixel_count < pixel_cap) begin
                row_total   = row_total + 24'(row);
                level_total = level_total + 20'(lvl);
                pixel_count = pixel_count + 13'd1;
            end
            if (last) begin
                res[k] = close_column();
                k++;
            end
            if (k > 0)
                res[k-1].end_of_run = 1'b1;
            for (int i = 0; i < k; i++)
                pending_means.push_back(res[i]);
        endfunction

        task check_mean(logic [31:0] data, logic last);
            column_mean_t exp_mean;
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%h last=%b", data, last));
            end else begin
                exp_mean = pending_means.pop_front();
                if (data[11:0] !== exp_mean.column)
                    report_mismatch($sformatf("column got %0d want %0d",
                                              data[11:0], exp_mean.column));
                if (data[23:12] !== exp_mean.row_mean)
                    report_mismatch($sformatf("column %0d row mean got %0d want %0d",
                                              exp_mean.column, data[23:12],
                                              exp_mean.row_mean));
                if (data[31:24] !== exp_mean.level_mean)
                    report_mismatch($sformatf("column %0d level mean got %0d want %0d",
                                              exp_mean.column, data[31:24],
                                              exp_mean.level_mean));
                if (last !== exp_mean.end_of_run)
                    report_mismatch($sformatf("column %0d end of run got %b want %b",
                                              exp_mean.column, last, exp_mean.end_of_run));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;    // column[11:0], row[23:12], level[31:24]
    logic        i_s_axis_tlast;    // last_pixel
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;    // out_column[11:0], row_mean[23:12], level_mean[31:24]
    logic        o_m_axis_tlast;    // end_of_run

    column_mean_predictor means = new();

    int unsigned cycle_count;
    int unsigned pixels_sent;
    int unsigned means_checked;
    int unsigned frames_sent;
    int unsigned hold_off_cycles;
    bit          tx_idle;
    bit          rx_idle;
    bit          reset_done;

    column_mean_line_extractor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sample both sides at the edge, before the drivers' updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                means.note_pixel(i_s_axis_tdata[11:0], i_s_axis_tdata[23:12],
                                 i_s_axis_tdata[31:24], i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                means.check_mean(o_m_axis_tdata, o_m_axis_tlast);
                means_checked++;
            end
        end
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        i_m_axis_tready = 1'b0;
        while (!reset_done) @(posedge i_clk);
        forever begin
            if (hold_off_cycles != 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid && hold_off_cycles == 0);
        end
    end

    task automatic send_pixel(bit [11:0] col, bit [11:0] row, bit [7:0] lvl, bit last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {lvl, row, col};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixels_sent++;
        if (last)
            frames_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (means.pending() != 0) @(posedge i_clk);
    endtask

    function automatic bit [11:0] pick_row();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic bit [7:0] pick_level();
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'hFF;
            2:       return 8'd1;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // well-formed frame of ascending columns, with the odd stray pixel or drop
    task automatic send_frame();
        int unsigned n_cols;
        int unsigned depth;
        int          col;
        n_cols = $urandom_range(1, 8);
        col    = ($urandom_range(0, 4) == 0) ? $urandom_range(4080, 4095)
                                             : $urandom_range(0, 4095);
        for (int c = 0; c < n_cols; c++) begin
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                : $urandom_range(1, 4);
            for (int p = 0; p < depth; p++) begin
                if ($urandom_range(0, 14) == 0)
                    send_pixel(12'($urandom), 12'($urandom), 8'($urandom),
                               1'($urandom));
                else
                    send_pixel(12'(col), pick_row(), pick_level(),
                               c == n_cols - 1 && p == depth - 1);
            end
            if ($urandom_range(0, 11) == 0)
                col = col - $urandom_range(1, 40);
            else
                col = col + (($urandom_range(0, 7) == 0) ? $urandom_range(4, 500)
                                                          : $urandom_range(1, 3));
            if (col < 0 || col > 4095)
                col = $urandom_range(0, 4095);
        end
    endtask

    initial begin : stimulus
        cycle_count     = 0;
        pixels_sent     = 0;
        means_checked   = 0;
        frames_sent     = 0;
        hold_off_cycles = 0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        reset_done      = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);

        // directed: no open column, zero level, extremes, ties, flushes
        send_pixel(12'd0,    12'd0,    8'd0,   1'b0);
        send_pixel(12'd0,    12'hFFF,  8'hFF,  1'b0);
        send_pixel(12'hFFF,  12'd1,    8'd1,   1'b0);
        send_pixel(12'hFFF,  12'd2,    8'd2,   1'b0);
        send_pixel(12'hFFF,  12'd4,    8'd4,   1'b1);
        send_pixel(12'd10,   12'd5,    8'd3,   1'b1);
        send_pixel(12'd20,   12'd1,    8'd1,   1'b0);
        send_pixel(12'd21,   12'd3,    8'd3,   1'b1);
        send_pixel(12'd100,  12'd2,    8'd2,   1'b0);
        send_pixel(12'd100,  12'd3,    8'd5,   1'b0);
        // column drops back
        send_pixel(12'd50,   12'hFFF,  8'hFF,  1'b0);
        send_pixel(12'd50,   12'hFFE,  8'hFE,  1'b0);
        send_pixel(12'd51,   12'd1,    8'd1,   1'b0);
        send_pixel(12'd51,   12'd1,    8'd1,   1'b0);
        send_pixel(12'd51,   12'd1,    8'd1,   1'b0);
        send_pixel(12'd51,   12'd2,    8'd2,   1'b1);
        send_pixel(12'hAAA,  12'h555,  8'hAA,  1'b0);
        send_pixel(12'h555,  12'hAAA,  8'h55,  1'b1);
        wait_drained();

        // hold the output off while a burst of one-pixel columns fills the queue
        hold_off_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_pixel(12'(200 + i), pick_row(), pick_level(), i == 29);
        wait_drained();

        while (pixels_sent < RANDOM_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            send_frame();
        end
        i_s_axis_tvalid <= 1'b0;

        while (means.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (means.pending() != 0)
            means.report_mismatch($sformatf("%0d results never arrived", means.pending()));

        $display("Sent %0d pixels in %0d frames, including directed edge cases", pixels_sent,
                 frames_sent);
        $display("Checked %0d column means under random stalls and a long output hold-off",
                 means_checked);
        if (means.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
